// ===== hw/rtl/column_melt_wipe_defines.svh =====
// Assertion macros shared by the column melt wipe RTL.
// CMW_ASSERT expects clk_i and rst_ni in scope where it is used; CMW_ASSERT_ALWAYS needs only clk_i.
`ifndef COLUMN_MELT_WIPE_DEFINES_SVH
`define COLUMN_MELT_WIPE_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define CMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, also while reset is held.
`define CMW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/cmw_pkg.sv =====
// Shared types, constants and helpers for the column melt wipe block.
// Has no dependencies; used by cmw_col_mem, cmw_update and column_melt_wipe.
package cmw_pkg;

  localparam int unsigned ColumnsDefault = 512;
  localparam int unsigned MaxRowsDefault = 1024;

  localparam int unsigned ColW    = 9;
  localparam int unsigned PosW    = 12;
  localparam int unsigned RowsW   = 11;
  localparam int unsigned StepW   = 7;
  localparam int unsigned RandW   = 8;
  localparam int unsigned SeedW   = 5;
  localparam int unsigned CfgIdxW = 1;

  // Input mode codes.
  localparam logic [1:0] ModeSeedFirst = 2'd0;
  localparam logic [1:0] ModeSeedNext  = 2'd1;
  localparam logic [1:0] ModeAdvance   = 2'd2;
  localparam logic [1:0] ModeUnused    = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgFastStep     = 1'd1;

  localparam logic [RowsW-1:0] ScreenHeightReset = 11'd200;
  localparam logic [StepW-1:0] FastStepReset     = 7'd8;

  // Rows below this threshold drop by position+1 per advance.
  localparam logic signed [PosW:0] SlowZone = 13'sd16;

  typedef struct packed {
    logic signed [PosW-1:0] old_position;
    logic signed [PosW-1:0] new_position;
    logic [RowsW-1:0]       copy_rows;
    logic                   column_busy;
  } cmw_res_t;

  // A byte modulo 3: base-4 digits sum to the same residue since 4 is 1 mod 3.
  function automatic logic [1:0] mod3_byte(input logic [RandW-1:0] v);
    logic [3:0] s;
    logic [1:0] r;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
      default:                       r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/cmw_col_mem.sv =====
// Column position table: one write port, one read port with registered data.
// Depends on cmw_pkg for the position width.
module cmw_col_mem #(
  parameter int unsigned COLUMNS = cmw_pkg::ColumnsDefault,
  parameter int unsigned AddrW   = $clog2(COLUMNS)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AddrW-1:0]               waddr_i,
  input  logic signed [cmw_pkg::PosW-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [AddrW-1:0]               raddr_i,
  output logic signed [cmw_pkg::PosW-1:0] rdata_o
);
  import cmw_pkg::*;

  logic signed [PosW-1:0] mem [COLUMNS];
  logic signed [PosW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cmw_update.sv =====
// Next-position logic for one item: seeding and advancing a column.
// Depends on cmw_pkg for widths, mode codes and the result struct.
module cmw_update #(
  parameter int unsigned MAX_ROWS = cmw_pkg::MaxRowsDefault
) (
  input  logic [1:0]                       mode_i,
  input  logic [cmw_pkg::RandW-1:0]        random_value_i,
  input  logic signed [cmw_pkg::PosW-1:0]  cur_position_i,
  input  logic signed [cmw_pkg::SeedW-1:0] prev_seed_i,
  input  logic [cmw_pkg::RowsW-1:0]        screen_height_i,
  input  logic [cmw_pkg::StepW-1:0]        fast_step_i,
  output cmw_pkg::cmw_res_t                res_o,
  output logic                             seed_we_o,
  output logic signed [cmw_pkg::SeedW-1:0] seed_d_o
);
  import cmw_pkg::*;

  logic [RowsW-1:0]         height;
  logic signed [PosW:0]     hw;
  logic signed [PosW:0]     oldw;
  logic signed [PosW:0]     dy_raw;
  logic signed [PosW:0]     dy;
  logic signed [PosW:0]     sum;
  logic signed [SeedW-1:0]  seed_first;
  logic signed [SeedW:0]    seed_next_raw;
  logic signed [SeedW-1:0]  seed_next;

  assign height = (int'(screen_height_i) > MAX_ROWS) ? RowsW'(MAX_ROWS) : screen_height_i;
  assign hw     = $signed({2'b00, height});
  assign oldw   = (PosW+1)'(cur_position_i);

  always_comb begin
    dy_raw = (oldw < SlowZone) ? oldw + 13'sd1 : $signed({6'b0, fast_step_i});
    sum    = oldw + dy_raw;
    dy     = (sum >= hw) ? hw - oldw : dy_raw;
  end

  assign seed_first    = -$signed({1'b0, random_value_i[3:0]});
  assign seed_next_raw = (SeedW+1)'(prev_seed_i) + $signed({4'b0, mod3_byte(random_value_i)})
                         - 6'sd1;

  always_comb begin
    if (seed_next_raw > 6'sd0) begin
      seed_next = '0;
    end else if (seed_next_raw == -6'sd16) begin
      seed_next = -5'sd15;
    end else begin
      seed_next = SeedW'(seed_next_raw);
    end
  end

  always_comb begin
    res_o     = '0;
    seed_we_o = 1'b0;
    seed_d_o  = prev_seed_i;
    case (mode_i)
      ModeSeedFirst: begin
        seed_we_o          = 1'b1;
        seed_d_o           = seed_first;
        res_o.new_position = PosW'(seed_first);
        res_o.old_position = PosW'(seed_first);
        res_o.column_busy  = 1'b1;
      end
      ModeSeedNext: begin
        seed_we_o          = 1'b1;
        seed_d_o           = seed_next;
        res_o.new_position = PosW'(seed_next);
        res_o.old_position = PosW'(seed_next);
        res_o.column_busy  = 1'b1;
      end
      ModeAdvance: begin
        res_o.old_position = cur_position_i;
        res_o.new_position = cur_position_i;
        res_o.column_busy  = 1'b1;
        if (cur_position_i < 0) begin
          res_o.new_position = cur_position_i + 12'sd1;
        end else if (oldw < hw) begin
          res_o.new_position = PosW'(oldw + dy);
          res_o.copy_rows    = RowsW'(dy);
        end else begin
          // Already fully melted: nothing moves.
          res_o.column_busy = 1'b0;
        end
      end
      default: begin
        res_o.old_position = cur_position_i;
        res_o.new_position = cur_position_i;
      end
    endcase
  end

endmodule

// ===== hw/rtl/column_melt_wipe.sv =====
// Column melt wipe: an accepted item passes through the stage-one register, then the result register.
// Throughput is one item per cycle while the output is not stalled: one column table read on acceptance and one
// write as the item enters the result register, with a bypass for repeated columns.
// Reset clears the handshake state and the last seed, and sets both config registers to their reset values.
// The column table is not cleared; a column must be seeded before it is advanced.
// Top level; depends on cmw_pkg, cmw_col_mem, cmw_update and the defines header.
`include "column_melt_wipe_defines.svh"

module column_melt_wipe #(
  parameter int unsigned COLUMNS  = cmw_pkg::ColumnsDefault,
  parameter int unsigned MAX_ROWS = cmw_pkg::MaxRowsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cmw_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cmw_pkg::RowsW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      mode_i,
  input  logic [cmw_pkg::ColW-1:0]        column_i,
  input  logic [cmw_pkg::RandW-1:0]       random_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cmw_pkg::ColW-1:0]        column_out_o,
  output logic signed [cmw_pkg::PosW-1:0] old_position_o,
  output logic signed [cmw_pkg::PosW-1:0] new_position_o,
  output logic [cmw_pkg::RowsW-1:0]       copy_rows_o,
  output logic                            column_busy_o
);
  import cmw_pkg::*;

  localparam int unsigned AddrW = $clog2(COLUMNS);

  logic [RowsW-1:0]        height_q;
  logic [StepW-1:0]        fast_step_q;
  logic signed [SeedW-1:0] prev_seed_q;

  logic                    s1_valid_q;
  logic [1:0]              s1_mode_q;
  logic [ColW-1:0]         s1_col_q;
  logic [RandW-1:0]        s1_rnd_q;
  logic                    s1_byp_q;
  logic signed [PosW-1:0]  s1_byp_pos_q;

  logic                    out_valid_q;
  logic [ColW-1:0]         out_col_q;
  cmw_res_t                out_res_q;

  logic                    accept;
  logic                    take;
  logic                    s1_adv;
  logic                    s1_fire;
  logic                    bypass;
  logic signed [PosW-1:0]  mem_rdata;
  logic signed [PosW-1:0]  cur_position;
  cmw_res_t                upd_res;
  logic                    seed_we;
  logic signed [SeedW-1:0] seed_d;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;
  // Unused mode and out-of-range columns are accepted and dropped here.
  assign take       = accept && (mode_i != ModeUnused) && (int'(column_i) < COLUMNS);
  // The item leaving stage one writes this cycle; hand its value over directly.
  assign bypass     = take && s1_fire && (s1_col_q == column_i);

  cmw_col_mem #(
    .COLUMNS (COLUMNS),
    .AddrW   (AddrW)
  ) u_col_mem (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (AddrW'(s1_col_q)),
    .wdata_i (upd_res.new_position),
    .re_i    (take),
    .raddr_i (AddrW'(column_i)),
    .rdata_o (mem_rdata)
  );

  assign cur_position = s1_byp_q ? s1_byp_pos_q : mem_rdata;

  cmw_update #(
    .MAX_ROWS (MAX_ROWS)
  ) u_update (
    .mode_i          (s1_mode_q),
    .random_value_i  (s1_rnd_q),
    .cur_position_i  (cur_position),
    .prev_seed_i     (prev_seed_q),
    .screen_height_i (height_q),
    .fast_step_i     (fast_step_q),
    .res_o           (upd_res),
    .seed_we_o       (seed_we),
    .seed_d_o        (seed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= ScreenHeightReset;
      fast_step_q <= FastStepReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgScreenHeight: height_q    <= cfg_wdata_i;
        CfgFastStep:     fast_step_q <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_seed_q <= '0;
    end else begin
      if (take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire && seed_we) begin
        prev_seed_q <= seed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_mode_q    <= mode_i;
      s1_col_q     <= column_i;
      s1_rnd_q     <= random_value_i;
      s1_byp_q     <= bypass;
      s1_byp_pos_q <= upd_res.new_position;
    end
    if (s1_fire) begin
      out_col_q <= s1_col_q;
      out_res_q <= upd_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign column_out_o   = out_col_q;
  assign old_position_o = out_res_q.old_position;
  assign new_position_o = out_res_q.new_position;
  assign copy_rows_o    = out_res_q.copy_rows;
  assign column_busy_o  = out_res_q.column_busy;

  `CMW_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q && !s1_valid_q,
                     "pipeline not empty in reset")
  `CMW_ASSERT(a_stall_cause, !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i,
              "input stalled without a full pipeline")
  `CMW_ASSERT(a_seed_range, prev_seed_q <= 5'sd0 && prev_seed_q >= -5'sd15,
              "last seed out of range")
  `CMW_ASSERT(a_copy_span, out_valid_q && copy_rows_o != '0 |->
              new_position_o == PosW'(old_position_o + $signed({1'b0, copy_rows_o})),
              "copied rows do not match the move")
  `CMW_ASSERT(a_melted_still, out_valid_q && !column_busy_o |->
              copy_rows_o == '0 && new_position_o == old_position_o,
              "melted column moved")

endmodule
